// ===== sv/ipe_pkg.sv =====
// ----------------------------------------------------------------------------
// ipe_pkg
// Shared types and constants for the isolated pixel erase block: register
// indexes, item kinds, default image limits and the position flag group.
// ----------------------------------------------------------------------------
`default_nettype none

package ipe_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 256;
	localparam int unsigned MAX_HEIGHT_DEF = 256;

	localparam int unsigned CFG_W     = 9;
	localparam int unsigned REG_IDX_W = 1;
	localparam int unsigned COORD_W   = 8;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 9'd256;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 9'd256;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_FLUSH = 1'b1
	} kind_t;

	typedef struct packed {
		logic flushing;
		logic first_row;
		logic last_col;
		logic has_left;
		logic has_above;
	} pos_flags_t;

endpackage

`default_nettype wire

// ===== sv/ipe_line_buf.sv =====
// ----------------------------------------------------------------------------
// ipe_line_buf
// One-bit line store, one write and one read port, registered read data with
// bypass of a write to the address being read in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ipe_line_buf #(
	parameter int unsigned DEPTH = ipe_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic                     wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic                          rd_data_q
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/ipe_pos_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipe_pos_ctrl
// Raster position counters: column and row of the next item, the flush phase
// and the neighbour availability flags derived from them.
// ----------------------------------------------------------------------------
`default_nettype none

module ipe_pos_ctrl #(
	parameter int unsigned MAX_WIDTH  = ipe_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = ipe_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              step,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    width,
	input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   height,
	output logic      [$clog2(MAX_WIDTH)-1:0]      col,
	output logic      [$clog2(MAX_WIDTH)-1:0]      col_next,
	output logic      [$clog2(MAX_HEIGHT+1)-1:0]   row,
	output ipe_pkg::pos_flags_t                    flags
);

	localparam int unsigned CW  = $clog2(MAX_WIDTH);
	localparam int unsigned DW  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned DW1 = DW + 1;
	localparam int unsigned RW  = $clog2(MAX_HEIGHT + 1);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	always_comb begin
		flags.last_col  = (DW1'(col_q) + DW1'(1)) >= DW1'(width);
		flags.flushing  = row_q >= height;
		flags.first_row = row_q == '0;
		flags.has_above = row_q > RW'(1);
		flags.has_left  = col_q != '0;
	end

	always_comb begin
		if (!step) begin
			col_next = col_q;
		end else if (flags.last_col) begin
			col_next = '0;
		end else begin
			col_next = col_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			col_q <= col_next;
			if (flags.last_col) begin
				row_q <= flags.flushing ? '0 : row_q + RW'(1);
			end
		end
	end

	assign col = col_q;
	assign row = row_q;

endmodule

`default_nettype wire

// ===== sv/binary_isolated_pixel_erase.sv =====
// ----------------------------------------------------------------------------
// binary_isolated_pixel_erase
// One in-place raster pass over a binary image that inverts every pixel with
// no 4-neighbour of its own value; results come one row late.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   kind, pixel_in
//  out      source     out_valid / out_ready pixel_out, out_column, out_row,
//                                            image_done
//  cfg      sink       cfg_wr_en             cfg_index, cfg_data
//
//  one item per clock sustained while the result is not stalled; an item passes
//  through the input register and its result is held in the result register after that
//  the two line stores give one read and one write per cycle, which sets it
//  reset: 256 x 256 image, position at row 0 column 0; line stores not cleared
//  a stalled result holds the next item in the input register
// ----------------------------------------------------------------------------
`default_nettype none

module binary_isolated_pixel_erase #(
	parameter int unsigned MAX_WIDTH  = ipe_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = ipe_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [ipe_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [ipe_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            kind,
	input  wire logic                            pixel_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 pixel_out,
	output logic      [ipe_pkg::COORD_W-1:0]     out_column,
	output logic      [ipe_pkg::COORD_W-1:0]     out_row,
	output logic                                 image_done
);

	localparam int unsigned CW    = $clog2(MAX_WIDTH);
	localparam int unsigned DW    = $clog2(MAX_WIDTH + 1);
	localparam int unsigned RW    = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned CFG_W = ipe_pkg::CFG_W;
	localparam int unsigned WCMP  = (DW > CFG_W) ? DW : CFG_W;
	localparam int unsigned HCMP  = (RW > CFG_W) ? RW : CFG_W;

	// configuration
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [WCMP-1:0]  width_ext;
	logic [HCMP-1:0]  height_ext;
	logic [DW-1:0]    width_eff;
	logic [RW-1:0]    height_eff;

	// input register
	logic valid_s1;
	logic kind_s1;
	logic pix_s1;

	// position and window
	logic [CW-1:0]       col;
	logic [CW-1:0]       col_next;
	logic [CW-1:0]       right_addr;
	logic [RW-1:0]       row;
	ipe_pkg::pos_flags_t flags;
	logic                cur_q;
	logic                first_q;
	logic                left_q;
	logic                right_rd;
	logic                above_rd;

	// decision
	logic fire_s1;
	logic step;
	logic produce;
	logic same;
	logic fin;
	logic cur_d;

	// result register
	logic                        out_valid_q;
	logic                        pixel_q;
	logic [ipe_pkg::COORD_W-1:0] column_q;
	logic [ipe_pkg::COORD_W-1:0] row_q;
	logic                        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ipe_pkg::WIDTH_RESET;
			height_q <= ipe_pkg::HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_index == ipe_pkg::REG_IMAGE_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_index == ipe_pkg::REG_IMAGE_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	assign width_ext  = WCMP'(width_q);
	assign height_ext = HCMP'(height_q);

	always_comb begin
		if (width_q == '0) begin
			width_eff = DW'(1);
		end else if (width_ext > WCMP'(MAX_WIDTH)) begin
			width_eff = DW'(MAX_WIDTH);
		end else begin
			width_eff = DW'(width_ext);
		end
		if (height_q == '0) begin
			height_eff = RW'(1);
		end else if (height_ext > HCMP'(MAX_HEIGHT)) begin
			height_eff = RW'(MAX_HEIGHT);
		end else begin
			height_eff = RW'(height_ext);
		end
	end

	assign fire_s1  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			pix_s1  <= pixel_in;
		end
	end

	ipe_pos_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.width    (width_eff),
		.height   (height_eff),
		.col      (col),
		.col_next (col_next),
		.row      (row),
		.flags    (flags)
	);

	assign step    = fire_s1 && ((kind_s1 == ipe_pkg::KIND_FLUSH) == flags.flushing);
	assign produce = step && !flags.first_row;

	assign right_addr = (col_next == CW'(MAX_WIDTH - 1)) ? '0 : col_next + CW'(1);

	// original values of the pending row, read one column ahead
	ipe_line_buf #(
		.DEPTH (MAX_WIDTH)
	) u_orig_line (
		.clk       (clk),
		.wr_en     (step && !flags.flushing),
		.wr_addr   (col),
		.wr_data   (pix_s1),
		.rd_addr   (right_addr),
		.rd_data_q (right_rd)
	);

	// final values of the row above
	ipe_line_buf #(
		.DEPTH (MAX_WIDTH)
	) u_proc_line (
		.clk       (clk),
		.wr_en     (produce),
		.wr_addr   (col),
		.wr_data   (fin),
		.rd_addr   (col_next),
		.rd_data_q (above_rd)
	);

	always_comb begin
		same = (flags.has_left && (left_q == cur_q))
			|| (!flags.last_col && (right_rd == cur_q))
			|| (flags.has_above && (above_rd == cur_q))
			|| (!flags.flushing && (pix_s1 == cur_q));
		fin = same ? cur_q : !cur_q;
	end

	always_comb begin
		if (!flags.last_col) begin
			cur_d = right_rd;
		end else if (flags.has_left) begin
			cur_d = first_q;
		end else begin
			cur_d = pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			cur_q <= cur_d;
			if (!flags.flushing && !flags.has_left) begin
				first_q <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 1'b0;
		end else if (produce) begin
			left_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= produce;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			pixel_q  <= fin;
			column_q <= ipe_pkg::COORD_W'(col);
			row_q    <= ipe_pkg::COORD_W'(row - RW'(1));
			done_q   <= flags.flushing && flags.last_col;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_q;
	assign out_column = column_q;
	assign out_row    = row_q;
	assign image_done = done_q;

	a_end_of_pass: assert property (@(posedge clk) disable iff (!arst_n)
		step && flags.flushing && flags.last_col |=> row == '0 && col == '0)
		else $error("position not back at origin after the last pixel");

	a_col_advance: assert property (@(posedge clk) disable iff (!arst_n)
		step && !flags.last_col |=> col == $past(col) + CW'(1))
		else $error("column did not advance by one");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |=> valid_s1)
		else $error("item dropped while result stalled");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		produce |=> out_valid && out_column == $past(ipe_pkg::COORD_W'(col)))
		else $error("result not registered for processed pixel");

endmodule

`default_nettype wire

// ===== verif/binary_isolated_pixel_erase_tb.sv =====
// ----------------------------------------------------------------------------
// binary_isolated_pixel_erase_tb
// Self-checking bench for the isolated pixel erase block. Whole images are
// streamed in raster order with flush items for the last row. Ignored items
// are mixed in. A model of the in-place pass predicts every emitted pixel with
// its column, row and end-of-image flag. Image sizes are changed only between
// passes, and only once the block has drained. Both sides idle and stall at
// random.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_isolated_pixel_erase_tb;
	import ipe_pkg::*;

	localparam int unsigned CLK_PERIOD     = 8;
	localparam int unsigned TIMEOUT_CYCLES = 500000;
	localparam int unsigned DRAIN_CYCLES   = 4;
	localparam int unsigned RANDOM_TARGET  = 2000;
	localparam int unsigned MAX_REPORTS    = 10;

	typedef struct packed {
		kind_t kind;
		logic  pixel;
	} raster_item_t;

	typedef struct packed {
		logic               pixel;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic               done;
	} erased_pixel_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	reg_idx_t           cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	kind_t              kind = KIND_PIXEL;
	logic               pixel_in = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               pixel_out;
	logic [COORD_W-1:0] out_column;
	logic [COORD_W-1:0] out_row;
	logic               image_done;

	binary_isolated_pixel_erase u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.pixel_in   (pixel_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.out_column (out_column),
		.out_row    (out_row),
		.image_done (image_done)
	);

	raster_item_t  raster_queue [$];
	erased_pixel_t erased_queue [$];
	raster_item_t  next_item;
	erased_pixel_t predicted;
	erased_pixel_t got;
	erased_pixel_t want;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_off_cycles = 0;
	int unsigned random_items = 0;
	int unsigned fail_count = 0;

	// shadow of the registers and of the pass state
	logic [CFG_W-1:0] width_reg = WIDTH_RESET;
	logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
	bit               orig_row [MAX_WIDTH_DEF];
	bit               final_row [MAX_WIDTH_DEF];
	bit               left_final = 1'b0;
	int unsigned      col_pos = 0;
	int unsigned      row_pos = 0;

	function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return 32'(v);
	endfunction

	function automatic bit erase_step(input kind_t k, input logic px, output erased_pixel_t res);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		bit          flushing;
		bit          last_c;
		bit          keep;
		bit          orig;
		bit          fin;
		w = eff_dim(width_reg, MAX_WIDTH_DEF);
		h = eff_dim(height_reg, MAX_HEIGHT_DEF);
		flushing = row_pos >= h;
		c = col_pos;
		last_c = c + 1 >= w;
		res = '0;
		if ((k == KIND_FLUSH) != flushing)
			return 1'b0;
		if (c >= MAX_WIDTH_DEF)
			c = MAX_WIDTH_DEF - 1;
		// first row is only stored
		if (!flushing && row_pos == 0) begin
			orig_row[c] = px;
			col_pos = last_c ? 0 : c + 1;
			if (last_c)
				row_pos = 1;
			return 1'b0;
		end
		orig = orig_row[c];
		keep = (c > 0 && left_final == orig)
			|| (!last_c && orig_row[c+1] == orig)
			|| (row_pos > 1 && final_row[c] == orig)
			|| (!flushing && px == orig);
		fin = keep ? orig : ~orig;
		res.pixel = fin;
		res.column = c[COORD_W-1:0];
		res.row = COORD_W'(row_pos - 1);
		res.done = flushing && last_c;
		final_row[c] = fin;
		left_final = fin;
		if (!flushing)
			orig_row[c] = px;
		if (last_c) begin
			col_pos = 0;
			row_pos = flushing ? 0 : row_pos + 1;
		end else begin
			col_pos = c + 1;
		end
		return 1'b1;
	endfunction

	task automatic push_item(input kind_t k, input logic px);
		raster_queue.insert(raster_queue.size(), raster_item_t'{k, px});
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			width_reg = value;
		else
			height_reg = value;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (raster_queue.size() != 0 || in_valid || erased_queue.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// one full pass with random content, ignored items mixed in for some images
	task automatic queue_image(input int unsigned w, input int unsigned h);
		int unsigned density;
		int unsigned noise;
		case ($urandom_range(2))
			0: density = 10;
			1: density = 50;
			default: density = 90;
		endcase
		noise = ($urandom_range(3) == 0) ? 6 : 0;
		for (int unsigned r = 0; r < h; r++) begin
			for (int unsigned c = 0; c < w; c++) begin
				if ($urandom_range(99) < noise)
					push_item(KIND_FLUSH, 1'($urandom_range(1)));
				push_item(KIND_PIXEL, $urandom_range(99) < density);
			end
		end
		for (int unsigned c = 0; c < w; c++) begin
			if ($urandom_range(99) < noise)
				push_item(KIND_PIXEL, 1'($urandom_range(1)));
			push_item(KIND_FLUSH, 1'($urandom_range(1)));
		end
		random_items += w * h + w;
	endtask

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (raster_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = raster_queue.pop_front();
				in_valid <= 1'b1;
				kind <= next_item.kind;
				pixel_in <= next_item.pixel;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off_cycles != 0) begin
			hold_off_cycles--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && $urandom_range(99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{pixel_out, out_column, out_row, image_done};
				if (erased_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected result: pixel %0d col %0d row %0d done %0d",
							got.pixel, got.column, got.row, got.done);
				end else begin
					want = erased_queue.pop_front();
					if (got.pixel !== want.pixel || got.column !== want.column
						|| got.row !== want.row || got.done !== want.done) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display({"result mismatch: expected pixel %0d col %0d row %0d ",
								"done %0d, got pixel %0d col %0d row %0d done %0d"},
								want.pixel, want.column, want.row, want.done,
								got.pixel, got.column, got.row, got.done);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (erase_step(kind, pixel_in, predicted))
					erased_queue.insert(erased_queue.size(), predicted);
			end
		end
	end

	initial begin
		int unsigned phase;
		int unsigned wv;
		int unsigned hv;
		int unsigned images;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single pixel images, with ignored items on both sides
		write_reg(REG_IMAGE_WIDTH, '0);
		write_reg(REG_IMAGE_HEIGHT, '0);
		push_item(KIND_FLUSH, 1'b1);
		push_item(KIND_PIXEL, 1'b1);
		push_item(KIND_PIXEL, 1'b0);
		push_item(KIND_FLUSH, 1'b0);
		push_item(KIND_PIXEL, 1'b0);
		push_item(KIND_FLUSH, 1'b1);
		wait_drained();

		// 3x3 chequerboard, sender pauses before the last row
		write_reg(REG_IMAGE_WIDTH, CFG_W'(3));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(3));
		for (int i = 0; i < 9; i++) begin
			if (i == 6)
				wait_drained();
			push_item(KIND_PIXEL, (i % 2) == 0);
		end
		push_item(KIND_FLUSH, 1'b0);
		push_item(KIND_PIXEL, 1'b1);
		push_item(KIND_FLUSH, 1'b1);
		push_item(KIND_FLUSH, 1'b0);
		wait_drained();

		phase = 0;
		while (random_items < RANDOM_TARGET) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 62;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 62;
				end
				default: begin
					send_idle_pct = 30;
					recv_stall_pct = 30;
				end
			endcase
			case (phase)
				2: begin
					wv = 511;
					hv = 1;
				end
				4: begin
					wv = 8;
					hv = 6;
				end
				6: begin
					wv = 0;
					hv = 256;
				end
				default: begin
					wv = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 12);
					hv = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(1, 8);
				end
			endcase
			write_reg(REG_IMAGE_WIDTH, CFG_W'(wv));
			write_reg(REG_IMAGE_HEIGHT, CFG_W'(hv));
			wv = eff_dim(width_reg, MAX_WIDTH_DEF);
			hv = eff_dim(height_reg, MAX_HEIGHT_DEF);
			images = (wv * hv > 200) ? 1 : $urandom_range(1, 4);
			for (int unsigned n = 0; n < images; n++)
				queue_image(wv, hv);
			// long receiver hold-off so the block backs up into its input
			if (phase == 4)
				hold_off_cycles = 400;
			wait_drained();
			phase++;
		end

		repeat (20) @(negedge clk);
		if (erased_queue.size() != 0) begin
			fail_count++;
			$display("%0d expected results never arrived", erased_queue.size());
		end
		if (fail_count == 0)
			$display("binary_isolated_pixel_erase verification clean");
		else
			$display("binary_isolated_pixel_erase verification failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("binary_isolated_pixel_erase verification failed");
		$finish;
	end

endmodule

`default_nettype wire
